/* rtl/deq_pkg.sv */
`timescale 1ns / 1ps

package deq_pkg;

  localparam int READY_DEPTH = 64;
  localparam int WAIT_DEPTH  = 64;

  localparam int READY_AW = $clog2(READY_DEPTH);
  localparam int READY_CW = $clog2(READY_DEPTH + 1);
  localparam int WAIT_AW  = $clog2(WAIT_DEPTH);
  localparam int WAIT_CW  = $clog2(WAIT_DEPTH + 1);

  localparam int CMD_W   = 2;
  localparam int TAG_W   = 32;
  localparam int DELAY_W = 16;
  localparam int DROP_W  = 7;

  localparam logic [DROP_W-1:0] DROP_MAX = {DROP_W{1'b1}};

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH = 2'd0,
    CMD_POP  = 2'd1,
    CMD_TICK = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_t;

endpackage

/* rtl/deq_req_if.sv */
`timescale 1ns / 1ps

interface deq_req_if;
  logic                          valid;
  logic                          ready;
  logic [deq_pkg::CMD_W-1:0]     cmd;
  logic [deq_pkg::TAG_W-1:0]     event_tag;
  logic [deq_pkg::DELAY_W-1:0]   delay_ticks;

  modport source (output valid, cmd, event_tag, delay_ticks, input ready);
  modport sink (input valid, cmd, event_tag, delay_ticks, output ready);
endinterface

/* rtl/deq_rsp_if.sv */
`timescale 1ns / 1ps

interface deq_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         status;
  logic [deq_pkg::TAG_W-1:0]    ready_tag;
  logic [deq_pkg::DROP_W-1:0]   dropped_count;

  modport source (output valid, status, ready_tag, dropped_count, input ready);
  modport sink (input valid, status, ready_tag, dropped_count, output ready);
endinterface

/* rtl/deq_ram.sv */
`timescale 1ns / 1ps

module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/delayed_event_queue.sv */
`timescale 1ns / 1ps

// Delayed event queue: a ready ring and a wait ring of 32-bit event tags.
// Items arrive on req (cmd, event_tag, delay_ticks) and each one gives exactly
// one item on rsp (status, ready_tag, dropped_count), in order.
// A push with zero delay goes to the ready ring, otherwise to the wait ring;
// a full ring refuses it with status 1. A pop returns the oldest ready tag,
// or status 1 when the ready ring is empty. A tick walks every entry that was
// in the wait ring when it began: expired entries move to the ready ring (or
// are counted as dropped when it is full), the rest are decremented and put
// back at the tail.
// The block takes one item at a time. A push or unused command goes straight
// to S_DONE, a pop passes through S_POP for the ready ring read, and a tick
// through S_TICK for the wait ring entries: the wait ring memory is read one
// entry per cycle and its single write port recirculates one entry per cycle.
// req.ready is high only while no item is in progress. The result sits in an
// output register; a stalled receiver holds it and the next item's result
// waits until it is taken, though that item is still accepted.
// A synchronous reset empties both rings; the ring memories are not cleared.
module delayed_event_queue (
  input  logic      clk,
  input  logic      rst,
  deq_req_if.sink   req,
  deq_rsp_if.source rsp
);

  localparam int RAW = deq_pkg::READY_AW;
  localparam int RCW = deq_pkg::READY_CW;
  localparam int WAW = deq_pkg::WAIT_AW;
  localparam int WCW = deq_pkg::WAIT_CW;
  localparam int TW  = deq_pkg::TAG_W;
  localparam int DW  = deq_pkg::DELAY_W;

  typedef enum logic [1:0] {S_IDLE, S_POP, S_TICK, S_DONE} state_t;

  state_t state;

  logic [RAW-1:0] ready_head, ready_head_next;
  logic [RAW-1:0] ready_tail, ready_tail_next;
  logic [RCW-1:0] ready_count, ready_count_next;
  logic [WAW-1:0] wait_head, wait_head_next;
  logic [WAW-1:0] wait_tail, wait_tail_next;
  logic [WCW-1:0] wait_count, wait_count_next;

  logic [WCW-1:0]                 rd_left;
  logic                           proc_valid;
  logic                           res_status;
  logic [TW-1:0]                  res_tag;
  logic [deq_pkg::DROP_W-1:0]     res_drop;

  logic                           out_valid;
  logic                           out_status;
  logic [TW-1:0]                  out_tag;
  logic [deq_pkg::DROP_W-1:0]     out_drop;

  logic          accept;
  logic          r_full, r_empty, w_full;
  logic          r_put, r_get, w_put, w_get;
  logic [TW-1:0] r_wdata, r_rdata;
  logic [TW+DW-1:0] w_wdata, w_rdata;
  logic [TW-1:0] w_rd_tag;
  logic [DW-1:0] w_rd_delay;
  logic          load_out;

  assign accept     = req.valid && req.ready;
  assign r_full     = (ready_count == RCW'(deq_pkg::READY_DEPTH));
  assign r_empty    = (ready_count == '0);
  assign w_full     = (wait_count == WCW'(deq_pkg::WAIT_DEPTH));
  assign w_rd_tag   = w_rdata[TW+DW-1:DW];
  assign w_rd_delay = w_rdata[DW-1:0];
  assign load_out   = (state == S_DONE) && (!out_valid || rsp.ready);

  assign req.ready         = (state == S_IDLE);
  assign rsp.valid         = out_valid;
  assign rsp.status        = out_status;
  assign rsp.ready_tag     = out_tag;
  assign rsp.dropped_count = out_drop;

  always_comb begin
    r_put   = 1'b0;
    r_get   = 1'b0;
    w_put   = 1'b0;
    w_get   = 1'b0;
    r_wdata = '0;
    w_wdata = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (req.cmd)
            deq_pkg::CMD_PUSH: begin
              if (req.delay_ticks == '0) begin
                r_put   = !r_full;
                r_wdata = req.event_tag;
              end else begin
                w_put   = !w_full;
                w_wdata = {req.event_tag, req.delay_ticks};
              end
            end
            deq_pkg::CMD_POP:  r_get = !r_empty;
            deq_pkg::CMD_TICK: w_get = (wait_count != '0);
            default: ;
          endcase
        end
      end
      S_TICK: begin
        if (proc_valid) begin
          if (w_rd_delay == '0) begin
            r_put   = !r_full;
            r_wdata = w_rd_tag;
          end else begin
            w_put   = 1'b1;
            w_wdata = {w_rd_tag, w_rd_delay - DW'(1)};
          end
        end
        w_get = (rd_left != '0);
      end
      default: ;
    endcase

    ready_head_next = ready_head;
    if (r_get) begin
      ready_head_next = (ready_head == RAW'(deq_pkg::READY_DEPTH - 1)) ? '0
                                                                        : ready_head + RAW'(1);
    end
    ready_tail_next = ready_tail;
    if (r_put) begin
      ready_tail_next = (ready_tail == RAW'(deq_pkg::READY_DEPTH - 1)) ? '0
                                                                        : ready_tail + RAW'(1);
    end
    ready_count_next = ready_count + RCW'(r_put) - RCW'(r_get);

    wait_head_next = wait_head;
    if (w_get) begin
      wait_head_next = (wait_head == WAW'(deq_pkg::WAIT_DEPTH - 1)) ? '0
                                                                     : wait_head + WAW'(1);
    end
    wait_tail_next = wait_tail;
    if (w_put) begin
      wait_tail_next = (wait_tail == WAW'(deq_pkg::WAIT_DEPTH - 1)) ? '0
                                                                     : wait_tail + WAW'(1);
    end
    wait_count_next = wait_count + WCW'(w_put) - WCW'(w_get);
  end

  deq_ram #(
    .WIDTH(TW),
    .DEPTH(deq_pkg::READY_DEPTH)
  ) u_ready_ram (
    .clk   (clk),
    .we    (r_put),
    .waddr (ready_tail),
    .wdata (r_wdata),
    .raddr (ready_head),
    .rdata (r_rdata)
  );

  deq_ram #(
    .WIDTH(TW + DW),
    .DEPTH(deq_pkg::WAIT_DEPTH)
  ) u_wait_ram (
    .clk   (clk),
    .we    (w_put),
    .waddr (wait_tail),
    .wdata (w_wdata),
    .raddr (wait_head),
    .rdata (w_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      ready_head  <= '0;
      ready_tail  <= '0;
      ready_count <= '0;
      wait_head   <= '0;
      wait_tail   <= '0;
      wait_count  <= '0;
      rd_left     <= '0;
      proc_valid  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      ready_head  <= ready_head_next;
      ready_tail  <= ready_tail_next;
      ready_count <= ready_count_next;
      wait_head   <= wait_head_next;
      wait_tail   <= wait_tail_next;
      wait_count  <= wait_count_next;
      proc_valid  <= w_get;

      if (load_out) begin
        out_valid  <= 1'b1;
        out_status <= res_status;
        out_tag    <= res_tag;
        out_drop   <= res_drop;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            res_status <= 1'b0;
            res_tag    <= '0;
            res_drop   <= '0;
            unique case (req.cmd)
              deq_pkg::CMD_PUSH: begin
                res_status <= (req.delay_ticks == '0) ? r_full : w_full;
                state      <= S_DONE;
              end
              deq_pkg::CMD_POP: begin
                res_status <= r_empty;
                state      <= r_empty ? S_DONE : S_POP;
              end
              deq_pkg::CMD_TICK: begin
                if (wait_count != '0) begin
                  rd_left <= wait_count - WCW'(1);
                  state   <= S_TICK;
                end else begin
                  state   <= S_DONE;
                end
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_POP: begin
          res_tag <= r_rdata;
          state   <= S_DONE;
        end
        S_TICK: begin
          if (proc_valid && (w_rd_delay == '0) && r_full && (res_drop != deq_pkg::DROP_MAX)) begin
            res_drop <= res_drop + deq_pkg::DROP_W'(1);
          end
          if (w_get) begin
            rd_left <= rd_left - WCW'(1);
          end
          if (rd_left == '0) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/deq_checker.sv */
`timescale 1ns / 1ps

module deq_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          req_valid,
  input logic                          req_ready,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic                          rsp_status,
  input logic [deq_pkg::TAG_W-1:0]     rsp_ready_tag,
  input logic [deq_pkg::DROP_W-1:0]    rsp_dropped_count
);

  // A result that is not taken stays offered.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result item withdrawn before it was taken");

  // The block works on one item at a time.
  assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while an item is in progress");

  // A failed push or pop carries no tag and no drops.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status |-> (rsp_ready_tag == '0) && (rsp_dropped_count == '0))
    else $error("failed item carries a tag or a drop count");

  // Drops only come from a tick, which never returns a tag.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_dropped_count != '0) |-> (rsp_ready_tag == '0))
    else $error("drop count reported together with a tag");

endmodule

bind delayed_event_queue deq_checker u_deq_checker (
  .clk               (clk),
  .rst               (rst),
  .req_valid         (req.valid),
  .req_ready         (req.ready),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .rsp_status        (rsp.status),
  .rsp_ready_tag     (rsp.ready_tag),
  .rsp_dropped_count (rsp.dropped_count)
);
